FILE: rtl/vspp_pkg.sv
// Package for the vector step pixel plotter: frame geometry, bus and
// latched command codes, controller states and control/status structs.
// No dependencies.
`default_nettype none

package vspp_pkg;

	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 256;
	localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int STORE_AW     = $clog2(STORE_DEPTH);

	typedef logic [STORE_AW-1:0] store_addr_t;

	// bus access codes
	typedef enum logic [1:0] {
		OP_CMD_WR  = 2'd0,
		OP_DATA_WR = 2'd1,
		OP_DATA_RD = 2'd2,
		OP_NOP     = 2'd3
	} vspp_op_t;

	// latched command codes
	localparam logic [7:0] CMD_STEP   = 8'h00;
	localparam logic [7:0] CMD_LOAD_X = 8'h08;
	localparam logic [7:0] CMD_LOAD_Y = 8'h10;
	localparam logic [7:0] CMD_FILL   = 8'h18;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FILL
	} vspp_state_t;

	typedef struct packed {
		logic latch_wr;
		logic data_wr;
		logic rd_issue;
		logic out_load;
		logic sweep_en;
	} vspp_cmd_t;

	typedef struct packed {
		logic latch_is_fill;
		logic sweep_last;
		logic out_free;
	} vspp_sts_t;

	function automatic logic in_frame(input logic [7:0] y);
		return {1'b0, y} < 9'(FRAME_HEIGHT);
	endfunction

	function automatic store_addr_t store_index(input logic [7:0] x, input logic [7:0] y);
		logic [15:0] flat;
		flat = {y, x};
		return flat[STORE_AW-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/vspp_if.sv
// Valid/ready channel interfaces for bus accesses and read results.
// No dependencies.
`default_nettype none

interface vspp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data;

	modport source (output valid, output command, output data, input ready);
	modport sink (input valid, input command, input data, output ready);
endinterface

interface vspp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/vspp_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module vspp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/vspp_ctrl.sv
// Controller: sequences clearing, bus accesses, reads and fills.
// Depends on vspp_pkg.
`default_nettype none

module vspp_ctrl
	import vspp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_command,
	output      logic       req_ready,
	input  wire vspp_sts_t  sts,
	output      vspp_cmd_t  cmd
);

	vspp_state_t state_q, state_d;
	vspp_op_t    op;

	assign op = vspp_op_t'(req_command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR, ST_FILL: begin
				cmd.sweep_en = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (op)
						OP_CMD_WR: cmd.latch_wr = 1'b1;
						OP_DATA_WR: begin
							cmd.data_wr = 1'b1;
							if (sts.latch_is_fill) begin
								state_d = ST_FILL;
							end
						end
						OP_DATA_RD: begin
							cmd.rd_issue = 1'b1;
							state_d      = ST_READ;
						end
						OP_NOP: ;
						default: ;
					endcase
				end
			end
			ST_READ: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/vspp_dp.sv
// Datapath: command latch, cursor, deferred pixel, sweep counter,
// frame store and result register. Depends on vspp_pkg and vspp_ram.
`default_nettype none

module vspp_dp
	import vspp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] req_data,
	input  wire logic       rsp_ready,
	output      logic       rsp_valid,
	output      logic [7:0] rsp_read_data,
	input  wire vspp_cmd_t  cmd,
	output      vspp_sts_t  sts
);

	logic [7:0]  latch_q;
	logic [7:0]  cur_x_q, cur_y_q;
	logic        def_valid_q;
	logic [7:0]  def_x_q, def_y_q;
	logic [3:0]  def_colour_q;
	logic [7:0]  fill_q;
	store_addr_t sweep_q;
	logic        rd_in_frame_q;
	logic        rsp_valid_q;
	logic [7:0]  rsp_data_q;

	logic [7:0]  step_x, step_y;
	logic [3:0]  dir;
	logic        sweep_last;
	logic        ram_we;
	store_addr_t ram_waddr;
	logic [7:0]  ram_wdata;
	logic [7:0]  ram_rdata;

	assign dir = req_data[7:4];

	always_comb begin
		step_x = cur_x_q;
		step_y = cur_y_q;
		if (dir[0]) begin
			step_x = dir[2] ? cur_x_q - 8'd1 : cur_x_q + 8'd1;
		end
		if (dir[1]) begin
			step_y = dir[3] ? cur_y_q - 8'd1 : cur_y_q + 8'd1;
		end
	end

	assign sweep_last = sweep_q == STORE_AW'(STORE_DEPTH - 1);

	always_comb begin
		if (cmd.sweep_en) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = fill_q;
		end else begin
			ram_we    = cmd.data_wr && def_valid_q && in_frame(def_y_q);
			ram_waddr = store_index(def_x_q, def_y_q);
			ram_wdata = {4'd0, def_colour_q};
		end
	end

	vspp_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_issue),
		.raddr(store_index(cur_x_q, cur_y_q)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q      <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			def_valid_q  <= 1'b0;
			def_x_q      <= '0;
			def_y_q      <= '0;
			def_colour_q <= '0;
			fill_q       <= '0;
			sweep_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.latch_wr) begin
				latch_q <= req_data;
			end
			if (cmd.data_wr) begin
				def_valid_q <= latch_q == CMD_STEP;
				unique case (latch_q)
					CMD_STEP: begin
						cur_x_q      <= step_x;
						cur_y_q      <= step_y;
						def_x_q      <= step_x;
						def_y_q      <= step_y;
						def_colour_q <= req_data[3:0];
					end
					CMD_LOAD_X: cur_x_q <= req_data;
					CMD_LOAD_Y: cur_y_q <= req_data;
					CMD_FILL:   fill_q  <= req_data;
					default: ;
				endcase
			end
			if (cmd.sweep_en) begin
				sweep_q <= sweep_last ? '0 : sweep_q + STORE_AW'(1);
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_in_frame_q <= in_frame(cur_y_q);
		end
		if (cmd.out_load) begin
			rsp_data_q <= rd_in_frame_q ? ram_rdata : 8'd0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign rsp_read_data = rsp_data_q;

	assign sts.latch_is_fill = latch_q == CMD_FILL;
	assign sts.sweep_last    = sweep_last;
	assign sts.out_free      = !rsp_valid_q || rsp_ready;

endmodule

`default_nettype wire

FILE: rtl/vector_step_pixel_plotter.sv
// Top level of the vector step pixel plotter: controller, datapath and
// channel interfaces. Depends on vspp_pkg, vspp_if, vspp_ctrl, vspp_dp.
//
// Usage:
//   req carries bus accesses (command, data); rsp carries read results.
//   A command register write, a data write other than a fill and a
//   no-op leave the controller idle; the next beat is accepted on the
//   following cycle. In a read, the frame store read is registered,
//   then the byte moves into the result register and rsp.valid rises.
//   The next request beat is accepted while that result waits.
//   A data write under the fill command starts a sweep: a counter
//   walks the frame store one address a cycle through its single write
//   port, and req.ready stays low meanwhile.
//   After reset req.ready stays low while the same counter clears
//   every frame store entry to zero.
//   When the receiver stalls, the result holds in the register; a second
//   read waits for that slot to free before completing.
`default_nettype none

module vector_step_pixel_plotter
	import vspp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	vspp_req_if.sink   req,
	vspp_rsp_if.source rsp
);

	vspp_cmd_t cmd;
	vspp_sts_t sts;

	vspp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_command(req.command),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	vspp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_data     (req.data),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.rsp_read_data(rsp.read_data),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

`default_nettype wire

FILE: tb/vector_step_pixel_plotter_test.sv
// Regression testbench for vector_step_pixel_plotter: directed and random bus traffic
// checked against an in-bench model of the cursor, the deferred pixel and the frame store.
// Depends on vspp_pkg, vspp_if and the plotter RTL.
`timescale 1ns / 1ps

module vector_step_pixel_plotter_test;
	import vspp_pkg::*;

	localparam int RANDOM_BEATS = 1700;
	localparam int FILL_BUDGET  = 3;

	logic clk;
	logic arst_n;

	vspp_req_if req_ch();
	vspp_rsp_if rsp_ch();

	vector_step_pixel_plotter dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [7:0] pix_latch;
	logic [7:0] pix_cx;
	logic [7:0] pix_cy;
	logic       pix_def_valid;
	logic [7:0] pix_def_x;
	logic [7:0] pix_def_y;
	logic [3:0] pix_def_colour;
	logic [7:0] pix_store [STORE_DEPTH];

	logic [7:0] read_bytes_q [$];

	int  error_count;
	int  beats_sent;
	int  reads_checked;
	int  fills_done;
	int  rsp_hold;
	bit  no_idle;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(40_000_000);
		$display("vector_step_pixel_plotter regression: fail");
		$finish;
	end

	function automatic int pix_addr(input logic [7:0] x, input logic [7:0] y);
		return int'(y) * FRAME_WIDTH + int'(x);
	endfunction

	function automatic bit row_in_frame(input logic [7:0] y);
		return int'(y) < FRAME_HEIGHT;
	endfunction

	task automatic plotter_apply(input vspp_op_t op, input logic [7:0] d);
		logic [3:0] dir;
		case (op)
			OP_CMD_WR: pix_latch = d;
			OP_DATA_RD: begin
				if (row_in_frame(pix_cy))
					read_bytes_q.push_back(pix_store[pix_addr(pix_cx, pix_cy)]);
				else
					read_bytes_q.push_back(8'h00);
			end
			OP_DATA_WR: begin
				if (pix_def_valid) begin
					if (row_in_frame(pix_def_y))
						pix_store[pix_addr(pix_def_x, pix_def_y)] = {4'h0, pix_def_colour};
					pix_def_valid = 1'b0;
				end
				case (pix_latch)
					CMD_STEP: begin
						dir = d[7:4];
						if (dir[0])
							pix_cx = dir[2] ? pix_cx - 8'd1 : pix_cx + 8'd1;
						if (dir[1])
							pix_cy = dir[3] ? pix_cy - 8'd1 : pix_cy + 8'd1;
						pix_def_valid  = 1'b1;
						pix_def_x      = pix_cx;
						pix_def_y      = pix_cy;
						pix_def_colour = d[3:0];
					end
					CMD_LOAD_X: pix_cx = d;
					CMD_LOAD_Y: pix_cy = d;
					CMD_FILL: begin
						for (int i = 0; i < STORE_DEPTH; i++)
							pix_store[i] = d;
						fills_done++;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endtask

	task automatic send_beat(input vspp_op_t op, input logic [7:0] d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.command <= op;
		req_ch.data    <= d;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		plotter_apply(op, d);
		beats_sent++;
	endtask

	task automatic send_read();
		send_beat(OP_DATA_RD, 8'($urandom));
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (read_bytes_q.size() == 0) begin
				$display("%0t: unexpected read beat, expected none, actual %02h",
					$time, rsp_ch.read_data);
				error_count++;
			end else begin
				if (rsp_ch.read_data !== read_bytes_q[0]) begin
					$display("%0t: read_data mismatch, expected %02h, actual %02h",
						$time, read_bytes_q[0], rsp_ch.read_data);
					error_count++;
				end
				void'(read_bytes_q.pop_front());
			end
			reads_checked++;
			rsp_hold = no_idle ? 0 : $urandom_range(0, 12);
		end
	end

	task automatic test_clear_after_reset();
		send_read();
	endtask

	task automatic test_cursor_loads();
		send_beat(OP_CMD_WR, CMD_LOAD_X);
		send_beat(OP_DATA_WR, 8'hff);
		send_beat(OP_CMD_WR, CMD_LOAD_Y);
		send_beat(OP_DATA_WR, 8'hff);
		send_read();
	endtask

	task automatic test_step_directions();
		send_beat(OP_CMD_WR, CMD_STEP);
		send_beat(OP_DATA_WR, 8'h3a);
		send_beat(OP_DATA_WR, 8'hc5);
		send_read();
		send_beat(OP_DATA_WR, 8'hf7);
		send_read();
		send_beat(OP_DATA_WR, 8'h00);
		send_read();
	endtask

	task automatic test_unknown_and_nop();
		send_beat(OP_CMD_WR, 8'hff);
		send_beat(OP_DATA_WR, 8'h12);
		send_beat(OP_NOP, 8'hab);
		send_read();
	endtask

	task automatic test_fill();
		send_beat(OP_CMD_WR, CMD_FILL);
		send_beat(OP_DATA_WR, 8'ha5);
		send_beat(OP_CMD_WR, CMD_STEP);
		send_read();
	endtask

	function automatic logic [7:0] near_edge_coord();
		case ($urandom_range(0, 7))
			0: return 8'($urandom);
			1, 2: return 8'($urandom_range(252, 255));
			default: return 8'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic test_random_traffic();
		int         target;
		int         fills_left;
		int         pick;
		int         n;
		logic [7:0] d;
		logic [3:0] dir;
		vspp_op_t   op;
		target     = beats_sent + RANDOM_BEATS;
		fills_left = FILL_BUDGET;
		while (beats_sent < target) begin
			if ($urandom_range(0, 4) == 0)
				no_idle = ~no_idle;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				if (pix_latch != CMD_STEP || $urandom_range(0, 3) == 0)
					send_beat(OP_CMD_WR, CMD_STEP);
				n = $urandom_range(1, 8);
				repeat (n) begin
					dir = 4'($urandom);
					if ($urandom_range(0, 2) == 0)
						dir[1:0] = 2'b00;
					send_beat(OP_DATA_WR, {dir, 4'($urandom)});
					if ($urandom_range(0, 2) == 0)
						send_read();
				end
			end else if (pick < 75) begin
				send_beat(OP_CMD_WR, $urandom_range(0, 1) ? CMD_LOAD_X : CMD_LOAD_Y);
				send_beat(OP_DATA_WR, near_edge_coord());
				send_read();
			end else if (pick < 85) begin
				do d = 8'($urandom);
				while (d == CMD_STEP || d == CMD_LOAD_X || d == CMD_LOAD_Y || d == CMD_FILL);
				send_beat(OP_CMD_WR, d);
				n = $urandom_range(1, 3);
				repeat (n) send_beat(OP_DATA_WR, 8'($urandom));
				send_read();
			end else if (pick < 95 || fills_left == 0 || $urandom_range(0, 3) != 0) begin
				op = vspp_op_t'($urandom_range(0, 3));
				d  = 8'($urandom);
				if (op == OP_CMD_WR && d == CMD_FILL)
					d = CMD_FILL + 8'd1;
				send_beat(op, d);
			end else begin
				fills_left--;
				send_beat(OP_CMD_WR, CMD_FILL);
				send_beat(OP_DATA_WR, 8'($urandom));
				send_beat(OP_CMD_WR, CMD_STEP);
				send_read();
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.command = OP_NOP;
		req_ch.data    = 8'h00;
		error_count    = 0;
		beats_sent     = 0;
		reads_checked  = 0;
		fills_done     = 0;
		rsp_hold       = 0;
		no_idle        = 1'b0;
		pix_latch      = 8'h00;
		pix_cx         = 8'h00;
		pix_cy         = 8'h00;
		pix_def_valid  = 1'b0;
		pix_def_x      = 8'h00;
		pix_def_y      = 8'h00;
		pix_def_colour = 4'h0;
		for (int i = 0; i < STORE_DEPTH; i++)
			pix_store[i] = 8'h00;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_clear_after_reset();
		test_cursor_loads();
		test_step_directions();
		test_unknown_and_nop();
		test_fill();
		test_random_traffic();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (read_bytes_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Covered %0d bus beats, %0d read beats checked, %0d frame store fills.",
			beats_sent, reads_checked, fills_done);
		if (error_count == 0) begin
			$display("vector_step_pixel_plotter regression: pass");
		end else begin
			$display("%0d mismatches found.", error_count);
			$display("vector_step_pixel_plotter regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/vspp_pkg.sv
rtl/vspp_if.sv
rtl/vspp_ram.sv
rtl/vspp_ctrl.sv
rtl/vspp_dp.sv
rtl/vector_step_pixel_plotter.sv
tb/vector_step_pixel_plotter_test.sv
